[hdl/tsdf_pkg.sv]
package tsdf_pkg;

    localparam int NUM_DIGITS = 6;
    localparam int CHAR_MAX   = 4;
    localparam int RUN_MAX    = NUM_DIGITS + 1 + CHAR_MAX;
    localparam int CNT_W      = $clog2(RUN_MAX + 1);
    localparam int CHAR_CNT_W = $clog2(CHAR_MAX + 1);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_NUMBER_MODE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SQUEEZE_BLANK    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHOW_TABS        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SHOW_ENDS        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SHOW_NONPRINTING = 3'd4;

    localparam logic [1:0] NUM_NONE     = 2'd0;
    localparam logic [1:0] NUM_ALL      = 2'd1;
    localparam logic [1:0] NUM_NONBLANK = 2'd2;

    localparam logic [7:0] CH_TAB     = 8'd9;
    localparam logic [7:0] CH_NL      = 8'd10;
    localparam logic [7:0] CH_SPACE   = 8'd32;
    localparam logic [7:0] CH_ZERO    = 8'd48;
    localparam logic [7:0] CH_DEL     = 8'd127;
    localparam logic [7:0] CH_META    = 8'd128;
    localparam logic [7:0] CH_HIGH    = 8'd160;
    localparam logic [7:0] CH_MAX     = 8'd255;
    localparam logic [7:0] OFS_CTRL   = 8'd64;
    localparam logic [7:0] OFS_META   = 8'd128;
    localparam logic [7:0] CH_CARET   = 8'h5E;
    localparam logic [7:0] CH_I       = 8'h49;
    localparam logic [7:0] CH_DOLLAR  = 8'h24;
    localparam logic [7:0] CH_QUEST   = 8'h3F;
    localparam logic [7:0] CH_M       = 8'h4D;
    localparam logic [7:0] CH_DASH    = 8'h2D;

    typedef logic [NUM_DIGITS-1:0][3:0] bcd_t;
    typedef logic [NUM_DIGITS-1:0][7:0] digit_chars_t;
    typedef logic [RUN_MAX-1:0][7:0]    run_t;

    typedef struct packed {
        logic [1:0] number_mode;
        logic       squeeze_blank;
        logic       show_tabs;
        logic       show_ends;
        logic       show_nonprinting;
    } cfg_t;

    typedef struct packed {
        logic [CHAR_MAX-1:0][7:0] ch;
        logic [CHAR_CNT_W-1:0]    len;
    } render_t;

endpackage

[hdl/tsdf_render.sv]
module tsdf_render
(
    input  logic [7:0]       byte_in,
    input  tsdf_pkg::cfg_t   cfg,
    output tsdf_pkg::render_t rend
);

    always_comb
    begin
        rend = '0;
        priority if (byte_in == tsdf_pkg::CH_NL)
        begin
            if (cfg.show_ends)
            begin
                rend.ch[0] = tsdf_pkg::CH_DOLLAR;
                rend.ch[1] = tsdf_pkg::CH_NL;
                rend.len   = tsdf_pkg::CHAR_CNT_W'(2);
            end
            else
            begin
                rend.ch[0] = tsdf_pkg::CH_NL;
                rend.len   = tsdf_pkg::CHAR_CNT_W'(1);
            end
        end
        else if (byte_in == tsdf_pkg::CH_TAB && cfg.show_tabs)
        begin
            rend.ch[0] = tsdf_pkg::CH_CARET;
            rend.ch[1] = tsdf_pkg::CH_I;
            rend.len   = tsdf_pkg::CHAR_CNT_W'(2);
        end
        else if (!cfg.show_nonprinting || byte_in == tsdf_pkg::CH_TAB
                 || (byte_in >= tsdf_pkg::CH_SPACE && byte_in < tsdf_pkg::CH_DEL))
        begin
            rend.ch[0] = byte_in;
            rend.len   = tsdf_pkg::CHAR_CNT_W'(1);
        end
        else if (byte_in < tsdf_pkg::CH_SPACE)
        begin
            rend.ch[0] = tsdf_pkg::CH_CARET;
            rend.ch[1] = byte_in + tsdf_pkg::OFS_CTRL;
            rend.len   = tsdf_pkg::CHAR_CNT_W'(2);
        end
        else if (byte_in == tsdf_pkg::CH_DEL)
        begin
            rend.ch[0] = tsdf_pkg::CH_CARET;
            rend.ch[1] = tsdf_pkg::CH_QUEST;
            rend.len   = tsdf_pkg::CHAR_CNT_W'(2);
        end
        else if (byte_in == tsdf_pkg::CH_MAX)
        begin
            rend.ch[0] = tsdf_pkg::CH_M;
            rend.ch[1] = tsdf_pkg::CH_DASH;
            rend.ch[2] = tsdf_pkg::CH_CARET;
            rend.ch[3] = tsdf_pkg::CH_QUEST;
            rend.len   = tsdf_pkg::CHAR_CNT_W'(4);
        end
        else if (byte_in >= tsdf_pkg::CH_HIGH)
        begin
            rend.ch[0] = tsdf_pkg::CH_M;
            rend.ch[1] = tsdf_pkg::CH_DASH;
            rend.ch[2] = byte_in - tsdf_pkg::OFS_META;
            rend.len   = tsdf_pkg::CHAR_CNT_W'(3);
        end
        else
        begin
            rend.ch[0] = tsdf_pkg::CH_M;
            rend.ch[1] = tsdf_pkg::CH_DASH;
            rend.ch[2] = tsdf_pkg::CH_CARET;
            rend.ch[3] = byte_in - tsdf_pkg::OFS_CTRL;
            rend.len   = tsdf_pkg::CHAR_CNT_W'(4);
        end
    end

endmodule

[hdl/tsdf_number.sv]
module tsdf_number
(
    input  tsdf_pkg::bcd_t         count,
    output tsdf_pkg::digit_chars_t chars,
    output tsdf_pkg::bcd_t         count_inc
);

    logic [tsdf_pkg::NUM_DIGITS:0] low_nines;
    logic [tsdf_pkg::NUM_DIGITS:0] high_zero;
    logic                          saturated;

    always_comb
    begin
        low_nines[0] = 1'b1;
        for (int i = 0; i < tsdf_pkg::NUM_DIGITS; i++)
        begin
            low_nines[i+1] = low_nines[i] && (count[i] == 4'd9);
        end
        saturated = low_nines[tsdf_pkg::NUM_DIGITS];

        high_zero[tsdf_pkg::NUM_DIGITS] = 1'b1;
        for (int i = tsdf_pkg::NUM_DIGITS - 1; i >= 0; i--)
        begin
            high_zero[i] = high_zero[i+1] && (count[i] == 4'd0);
        end

        for (int i = 0; i < tsdf_pkg::NUM_DIGITS; i++)
        begin
            // blank leading zeros, keep the units digit
            if (high_zero[i] && i != 0)
                chars[i] = tsdf_pkg::CH_SPACE;
            else
                chars[i] = tsdf_pkg::CH_ZERO + {4'd0, count[i]};

            if (saturated || !low_nines[i])
                count_inc[i] = count[i];
            else if (count[i] == 4'd9)
                count_inc[i] = 4'd0;
            else
                count_inc[i] = count[i] + 4'd1;
        end
    end

endmodule

[hdl/text_stream_display_filter.sv]
// Text display filter in the manner of cat. Each accepted input byte becomes a run of
// zero to eleven displayed bytes on the output channel, marked last_of_run on its final
// byte: an optional six-column line number and tab, then the byte itself, or its ^, M-,
// ^I or $ rendering as configured. An accepted byte passes the input register, then the run
// register, to reach the output. While out_ready is high, a byte whose run is one output byte
// is taken every cycle and the run register shifts out one byte per cycle; the input stalls
// until the run is out. A squeezed empty line yields no output.
// Write the configuration registers only while no transaction is in flight.
module text_stream_display_filter
(
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             cfg_we,
    input  logic [tsdf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tsdf_pkg::CFG_DATA_W-1:0]  cfg_data,

    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [7:0]                       in_byte,
    input  logic                             file_start,

    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [7:0]                       out_byte,
    output logic                             last_of_run
);

    tsdf_pkg::cfg_t          cfg_reg;

    logic                    inr_valid_reg;
    logic [7:0]              inr_byte_reg;
    logic                    inr_start_reg;

    tsdf_pkg::bcd_t          count_reg;
    tsdf_pkg::bcd_t          count_next;
    logic                    line_start_reg;
    logic                    line_start_next;
    logic                    prev_blank_reg;
    logic                    prev_blank_next;

    tsdf_pkg::run_t          run_reg;
    tsdf_pkg::run_t          run_next;
    logic [tsdf_pkg::CNT_W-1:0] run_cnt_reg;
    logic [tsdf_pkg::CNT_W-1:0] run_cnt_next;

    tsdf_pkg::bcd_t          count_eff;
    tsdf_pkg::bcd_t          count_inc;
    tsdf_pkg::digit_chars_t  digit_chars;
    tsdf_pkg::render_t       rend;
    logic                    line_start_eff;
    logic                    prev_blank_eff;
    logic                    empty_line;
    logic                    drop;
    logic                    numbered;
    logic                    take;
    logic                    run_free;
    logic                    advance;
    tsdf_pkg::run_t          run_new;
    logic [tsdf_pkg::CNT_W-1:0] run_new_len;

    tsdf_render u_render
    (
        .byte_in (inr_byte_reg),
        .cfg     (cfg_reg),
        .rend    (rend)
    );

    tsdf_number u_number
    (
        .count     (count_eff),
        .chars     (digit_chars),
        .count_inc (count_inc)
    );

    assign out_valid   = (run_cnt_reg != '0);
    assign out_byte    = run_reg[0];
    assign last_of_run = (run_cnt_reg == tsdf_pkg::CNT_W'(1));
    assign take        = out_valid && out_ready;
    assign run_free    = !out_valid || (take && last_of_run);
    assign advance     = inr_valid_reg && run_free;
    assign in_ready    = !inr_valid_reg || run_free;

    always_comb
    begin
        count_eff      = '0;
        count_eff[0]   = 4'd1;
        if (!inr_start_reg)
            count_eff = count_reg;
        line_start_eff = inr_start_reg || line_start_reg;
        prev_blank_eff = !inr_start_reg && prev_blank_reg;

        empty_line = (inr_byte_reg == tsdf_pkg::CH_NL);
        drop       = line_start_eff && cfg_reg.squeeze_blank && empty_line && prev_blank_eff;
        numbered   = line_start_eff && !drop
                     && (cfg_reg.number_mode == tsdf_pkg::NUM_ALL
                         || (cfg_reg.number_mode >= tsdf_pkg::NUM_NONBLANK && !empty_line));

        count_next      = numbered ? count_inc : count_eff;
        line_start_next = drop ? 1'b1 : empty_line;
        prev_blank_next = (line_start_eff && !drop) ? empty_line : prev_blank_eff;

        run_new = '0;
        if (numbered)
        begin
            for (int k = 0; k < tsdf_pkg::NUM_DIGITS; k++)
            begin
                run_new[k] = digit_chars[tsdf_pkg::NUM_DIGITS-1-k];
            end
            run_new[tsdf_pkg::NUM_DIGITS] = tsdf_pkg::CH_TAB;
            for (int j = 0; j < tsdf_pkg::CHAR_MAX; j++)
            begin
                run_new[tsdf_pkg::NUM_DIGITS+1+j] = rend.ch[j];
            end
            run_new_len = tsdf_pkg::CNT_W'(tsdf_pkg::NUM_DIGITS + 1)
                          + tsdf_pkg::CNT_W'(rend.len);
        end
        else
        begin
            for (int j = 0; j < tsdf_pkg::CHAR_MAX; j++)
            begin
                run_new[j] = rend.ch[j];
            end
            run_new_len = tsdf_pkg::CNT_W'(rend.len);
        end
    end

    always_comb
    begin
        run_next     = run_reg;
        run_cnt_next = run_cnt_reg;
        if (advance)
        begin
            run_next     = run_new;
            run_cnt_next = drop ? '0 : run_new_len;
        end
        else if (take)
        begin
            // shift the run toward the output
            for (int k = 0; k < tsdf_pkg::RUN_MAX - 1; k++)
            begin
                run_next[k] = run_reg[k+1];
            end
            run_next[tsdf_pkg::RUN_MAX-1] = '0;
            run_cnt_next = run_cnt_reg - tsdf_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg        <= '0;
            inr_valid_reg  <= 1'b0;
            count_reg      <= tsdf_pkg::bcd_t'(1);
            line_start_reg <= 1'b1;
            prev_blank_reg <= 1'b0;
            run_cnt_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    tsdf_pkg::CFG_NUMBER_MODE:      cfg_reg.number_mode      <= cfg_data;
                    tsdf_pkg::CFG_SQUEEZE_BLANK:    cfg_reg.squeeze_blank    <= cfg_data[0];
                    tsdf_pkg::CFG_SHOW_TABS:        cfg_reg.show_tabs        <= cfg_data[0];
                    tsdf_pkg::CFG_SHOW_ENDS:        cfg_reg.show_ends        <= cfg_data[0];
                    tsdf_pkg::CFG_SHOW_NONPRINTING: cfg_reg.show_nonprinting <= cfg_data[0];
                    default:                        ;
                endcase
            end

            if (in_ready)
                inr_valid_reg <= in_valid;

            if (advance)
            begin
                count_reg      <= count_next;
                line_start_reg <= line_start_next;
                prev_blank_reg <= prev_blank_next;
            end

            run_cnt_reg <= run_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            inr_byte_reg  <= in_byte;
            inr_start_reg <= file_start;
        end
        run_reg <= run_next;
    end

endmodule

[tb/tb_top.sv]
module tb_top;

    localparam int         CYCLE_LIMIT  = 400000;
    localparam int         HOLD_CYCLES  = 120;

    typedef struct packed {
        logic [7:0] b;
        logic       fs;
    } text_item_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } shown_t;

    logic                            clk         = 1'b0;
    logic                            rst_n       = 1'b0;
    logic                            cfg_we      = 1'b0;
    logic [tsdf_pkg::CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [tsdf_pkg::CFG_DATA_W-1:0] cfg_data    = '0;
    logic                            in_valid    = 1'b0;
    logic                            in_ready;
    logic [7:0]                      in_byte     = 8'd0;
    logic                            file_start  = 1'b0;
    logic                            out_valid;
    logic                            out_ready   = 1'b0;
    logic [7:0]                      out_byte;
    logic                            last_of_run;

    text_item_t feed_q[$];
    shown_t     shown_q[$];
    text_item_t next_item;
    shown_t     want;

    tsdf_pkg::cfg_t cfg_model  = '0;
    tsdf_pkg::bcd_t line_bcd   = tsdf_pkg::bcd_t'(1);
    logic           at_sol     = 1'b1;
    logic           prev_blank = 1'b0;

    logic no_idle      = 1'b0;
    int   send_wait    = 0;
    int   recv_wait    = 0;
    int   hold_left    = 0;
    int   holds        = 0;
    int   results      = 0;
    int   errors       = 0;
    int   cycles       = 0;

    text_stream_display_filter u_top
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_byte     (in_byte),
        .file_start  (file_start),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .last_of_run (last_of_run)
    );

    always #6 clk = ~clk;

    function automatic int draw_wait();
        if (no_idle || $urandom_range(0, 1) == 0)
        begin
            return 0;
        end
        return $urandom_range(0, 12);
    endfunction

    // Displayed bytes for one input byte; updates line state
    task automatic render_byte(input logic [7:0] b, input logic fs);
        logic [7:0] run[$];
        logic       empty;
        logic       lead;
        logic       all9;
        logic       carry;
        int         i;
        shown_t     s;
        if (fs)
        begin
            line_bcd   = tsdf_pkg::bcd_t'(1);
            at_sol     = 1'b1;
            prev_blank = 1'b0;
        end
        if (at_sol)
        begin
            empty = (b == tsdf_pkg::CH_NL);
            if (cfg_model.squeeze_blank && empty && prev_blank)
            begin
                return;
            end
            prev_blank = empty;
            if (cfg_model.number_mode == tsdf_pkg::NUM_ALL ||
                (cfg_model.number_mode >= tsdf_pkg::NUM_NONBLANK && !empty))
            begin
                lead = 1'b1;
                for (i = tsdf_pkg::NUM_DIGITS - 1; i >= 0; i--)
                begin
                    if (line_bcd[i] != 4'd0 || i == 0)
                    begin
                        lead = 1'b0;
                    end
                    run.push_back(lead ? tsdf_pkg::CH_SPACE
                                       : tsdf_pkg::CH_ZERO + {4'd0, line_bcd[i]});
                end
                run.push_back(tsdf_pkg::CH_TAB);
                all9 = 1'b1;
                for (i = 0; i < tsdf_pkg::NUM_DIGITS; i++)
                begin
                    if (line_bcd[i] != 4'd9)
                    begin
                        all9 = 1'b0;
                    end
                end
                carry = !all9;
                for (i = 0; i < tsdf_pkg::NUM_DIGITS && carry; i++)
                begin
                    if (line_bcd[i] == 4'd9)
                    begin
                        line_bcd[i] = 4'd0;
                    end
                    else
                    begin
                        line_bcd[i] = line_bcd[i] + 4'd1;
                        carry       = 1'b0;
                    end
                end
            end
            at_sol = 1'b0;
        end
        if (b == tsdf_pkg::CH_NL)
        begin
            if (cfg_model.show_ends)
            begin
                run.push_back(tsdf_pkg::CH_DOLLAR);
            end
            run.push_back(tsdf_pkg::CH_NL);
            at_sol = 1'b1;
        end
        else if (b == tsdf_pkg::CH_TAB && cfg_model.show_tabs)
        begin
            run.push_back(tsdf_pkg::CH_CARET);
            run.push_back(tsdf_pkg::CH_I);
        end
        else if (cfg_model.show_nonprinting)
        begin
            if (b >= tsdf_pkg::CH_SPACE && b < tsdf_pkg::CH_DEL)
            begin
                run.push_back(b);
            end
            else if (b == tsdf_pkg::CH_DEL)
            begin
                run.push_back(tsdf_pkg::CH_CARET);
                run.push_back(tsdf_pkg::CH_QUEST);
            end
            else if (b >= tsdf_pkg::CH_META)
            begin
                run.push_back(tsdf_pkg::CH_M);
                run.push_back(tsdf_pkg::CH_DASH);
                if (b == tsdf_pkg::CH_MAX)
                begin
                    run.push_back(tsdf_pkg::CH_CARET);
                    run.push_back(tsdf_pkg::CH_QUEST);
                end
                else if (b >= tsdf_pkg::CH_HIGH)
                begin
                    run.push_back(b - tsdf_pkg::OFS_META);
                end
                else
                begin
                    run.push_back(tsdf_pkg::CH_CARET);
                    run.push_back(b - tsdf_pkg::OFS_CTRL);
                end
            end
            else if (b == tsdf_pkg::CH_TAB)
            begin
                run.push_back(b);
            end
            else
            begin
                run.push_back(tsdf_pkg::CH_CARET);
                run.push_back(b + tsdf_pkg::OFS_CTRL);
            end
        end
        else
        begin
            run.push_back(b);
        end
        for (i = 0; i < run.size(); i++)
        begin
            s.ch   = run[i];
            s.last = (i == run.size() - 1);
            shown_q.push_back(s);
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            in_byte    <= 8'd0;
            file_start <= 1'b0;
            send_wait = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                render_byte(in_byte, file_start);
                send_wait = draw_wait();
            end
            if (!in_valid || in_ready)
            begin
                if (send_wait > 0)
                begin
                    send_wait--;
                    in_valid <= 1'b0;
                end
                else if (feed_q.size() > 0)
                begin
                    next_item = feed_q.pop_front();
                    in_valid   <= 1'b1;
                    in_byte    <= next_item.b;
                    file_start <= next_item.fs;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_wait = 0;
            hold_left = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                results++;
                if (shown_q.size() == 0)
                begin
                    errors++;
                    $display("%0t unexpected transaction: out_byte %0d last_of_run %0d",
                             $time, out_byte, last_of_run);
                end
                else
                begin
                    want = shown_q.pop_front();
                    if (out_byte !== want.ch)
                    begin
                        errors++;
                        $display("%0t out_byte mismatch: expected %0d actual %0d",
                                 $time, want.ch, out_byte);
                    end
                    if (last_of_run !== want.last)
                    begin
                        errors++;
                        $display("%0t last_of_run mismatch: expected %0d actual %0d",
                                 $time, want.last, last_of_run);
                    end
                end
                recv_wait = draw_wait();
            end
            // hold off while the sender keeps offering, so the block backs up
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (holds < 2 && results > 40 + holds * 200 && feed_q.size() >= 15 && in_valid)
            begin
                hold_left = HOLD_CYCLES;
                holds++;
                out_ready <= 1'b0;
            end
            else if (recv_wait > 0)
            begin
                recv_wait--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic apply_cfg(input tsdf_pkg::cfg_t c);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= tsdf_pkg::CFG_NUMBER_MODE;
        cfg_data  <= c.number_mode;
        @(posedge clk);
        cfg_index <= tsdf_pkg::CFG_SQUEEZE_BLANK;
        cfg_data  <= {1'b0, c.squeeze_blank};
        @(posedge clk);
        cfg_index <= tsdf_pkg::CFG_SHOW_TABS;
        cfg_data  <= {1'b0, c.show_tabs};
        @(posedge clk);
        cfg_index <= tsdf_pkg::CFG_SHOW_ENDS;
        cfg_data  <= {1'b0, c.show_ends};
        @(posedge clk);
        cfg_index <= tsdf_pkg::CFG_SHOW_NONPRINTING;
        cfg_data  <= {1'b0, c.show_nonprinting};
        @(posedge clk);
        cfg_we <= 1'b0;
        cfg_model = c;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        while (feed_q.size() != 0 || in_valid || shown_q.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic push_item(input logic [7:0] b, input logic fs);
        text_item_t t;
        t.b  = b;
        t.fs = fs;
        feed_q.push_back(t);
    endtask

    function automatic logic [7:0] random_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
        begin
            return 8'($urandom_range(32, 126));
        end
        if (r < 60)
        begin
            return tsdf_pkg::CH_TAB;
        end
        if (r < 70)
        begin
            return 8'($urandom_range(0, 31));
        end
        if (r < 75)
        begin
            return tsdf_pkg::CH_DEL;
        end
        if (r < 87)
        begin
            return 8'($urandom_range(128, 159));
        end
        return 8'($urandom_range(160, 255));
    endfunction

    // Well-formed lines with random content, a little noise on file_start, sometimes an unterminated tail
    task automatic add_text(input int n_lines);
        int   k;
        int   i;
        int   r;
        int   len;
        logic fs;
        for (k = 0; k < n_lines; k++)
        begin
            r   = $urandom_range(0, 99);
            len = (r < 25) ? 0 : (r < 90) ? $urandom_range(1, 6) : $urandom_range(7, 12);
            fs  = ($urandom_range(0, 19) == 0);
            for (i = 0; i < len; i++)
            begin
                push_item(random_byte(), (i == 0 && fs) || $urandom_range(0, 39) == 0);
            end
            push_item(tsdf_pkg::CH_NL, len == 0 && fs);
        end
        if ($urandom_range(0, 4) == 0)
        begin
            len = $urandom_range(1, 4);
            for (i = 0; i < len; i++)
            begin
                push_item(random_byte(), 1'b0);
            end
        end
    endtask

    initial
    begin
        tsdf_pkg::cfg_t c;
        int             p;
        int             k;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        c = '{number_mode: tsdf_pkg::NUM_NONBLANK, squeeze_blank: 1'b1, show_tabs: 1'b0,
              show_ends: 1'b1, show_nonprinting: 1'b1};
        apply_cfg(c);
        push_item(8'd0, 1'b1);
        push_item(tsdf_pkg::CH_TAB, 1'b0);
        push_item(8'd31, 1'b0);
        push_item(tsdf_pkg::CH_DEL, 1'b0);
        push_item(tsdf_pkg::CH_META, 1'b0);
        push_item(8'd159, 1'b0);
        push_item(tsdf_pkg::CH_HIGH, 1'b0);
        push_item(8'd254, 1'b0);
        push_item(tsdf_pkg::CH_MAX, 1'b0);
        push_item(tsdf_pkg::CH_SPACE, 1'b0);
        push_item(8'd126, 1'b0);
        push_item(tsdf_pkg::CH_NL, 1'b0);
        push_item(tsdf_pkg::CH_NL, 1'b0);
        push_item(tsdf_pkg::CH_NL, 1'b0);
        push_item(tsdf_pkg::CH_NL, 1'b0);
        push_item(8'd65, 1'b0);
        push_item(tsdf_pkg::CH_NL, 1'b0);
        push_item(8'd66, 1'b1);
        push_item(tsdf_pkg::CH_NL, 1'b0);
        push_item(8'd200, 1'b0);
        wait_idle();

        for (p = 0; p < 9; p++)
        begin
            case (p)
                0: c = '{number_mode: tsdf_pkg::NUM_NONE, squeeze_blank: 1'b0,
                         show_tabs: 1'b0, show_ends: 1'b0, show_nonprinting: 1'b0};
                1: c = '{number_mode: 2'd3, squeeze_blank: 1'b1, show_tabs: 1'b1,
                         show_ends: 1'b1, show_nonprinting: 1'b1};
                2: c = '{number_mode: tsdf_pkg::NUM_ALL, squeeze_blank: 1'b0,
                         show_tabs: 1'b1, show_ends: 1'b0, show_nonprinting: 1'b1};
                3: c = '{number_mode: tsdf_pkg::NUM_NONBLANK, squeeze_blank: 1'b1,
                         show_tabs: 1'b0, show_ends: 1'b1, show_nonprinting: 1'b0};
                default:
                begin
                    c.number_mode      = 2'($urandom_range(0, 3));
                    c.squeeze_blank    = 1'($urandom_range(0, 1));
                    c.show_tabs        = 1'($urandom_range(0, 1));
                    c.show_ends        = 1'($urandom_range(0, 1));
                    c.show_nonprinting = 1'($urandom_range(0, 1));
                end
            endcase
            apply_cfg(c);
            no_idle = (p % 3 == 2);
            add_text(5);
            wait_idle();
        end

        // carry the line number past two digit boundaries
        c = '{number_mode: tsdf_pkg::NUM_ALL, squeeze_blank: 1'b0, show_tabs: 1'b0,
              show_ends: 1'b0, show_nonprinting: 1'b0};
        apply_cfg(c);
        no_idle = 1'b0;
        push_item(tsdf_pkg::CH_NL, 1'b1);
        for (k = 0; k < 104; k++)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                push_item(random_byte(), 1'b0);
            end
            push_item(tsdf_pkg::CH_NL, 1'b0);
        end
        wait_idle();

        repeat (20) @(posedge clk);
        if (errors == 0 && shown_q.size() == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
